/* hw/rtl/largest_empty_square_scan_core_macros.svh */
// Assertion macros shared by the scan core checker.
`ifndef LARGEST_EMPTY_SQUARE_SCAN_CORE_MACROS_SVH
`define LARGEST_EMPTY_SQUARE_SCAN_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LESSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LESSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lessc_pkg.sv */
// Package: widths, register map, reset values and stage control type of the scan core.
package lessc_pkg;

	localparam int SIZE_W     = 11;
	localparam int SYM_W      = 8;
	localparam int ROWLEN_W   = 11;
	localparam int END_ROW_W  = 12;
	localparam int END_COL_W  = 10;
	localparam int PDATA_W    = 32;
	localparam int PADDR_W    = 3;

	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 4096;

	localparam logic [SYM_W-1:0]    EMPTY_SYMBOL_RST = 8'd46;
	localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RST   = 11'd1024;

	// register index, taken from paddr[2]
	typedef enum logic [0:0] {
		REG_EMPTY_SYMBOL = 1'b0,
		REG_ROW_LENGTH   = 1'b1
	} reg_idx_t;

	// control that travels with a request through the compute stage
	typedef struct packed {
		logic valid;   // stage holds a request
		logic last;    // final cell of the map
		logic eol;     // final cell of its row
		logic row_nz;  // row above exists
	} stage_ctl_t;

endpackage

/* hw/rtl/lessc_regs.sv */
// Configuration registers behind the APB-style port.
module lessc_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lessc_pkg::PADDR_W-1:0]   paddr,
	input  logic [lessc_pkg::PDATA_W-1:0]   pwdata,
	output logic [lessc_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	output logic [lessc_pkg::SYM_W-1:0]     empty_symbol,
	output logic [lessc_pkg::ROWLEN_W-1:0]  row_length
);
	import lessc_pkg::*;

	logic [SYM_W-1:0]    empty_symbol_q;
	logic [ROWLEN_W-1:0] row_length_q;
	reg_idx_t            idx;
	logic                wr;

	assign idx   = reg_idx_t'(paddr[2]);
	assign wr    = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_symbol_q <= EMPTY_SYMBOL_RST;
			row_length_q   <= ROW_LENGTH_RST;
		end else if (wr) begin
			unique case (idx)
				REG_EMPTY_SYMBOL: empty_symbol_q <= pwdata[SYM_W-1:0];
				REG_ROW_LENGTH:   row_length_q   <= pwdata[ROWLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_EMPTY_SYMBOL: prdata = PDATA_W'(empty_symbol_q);
			REG_ROW_LENGTH:   prdata = PDATA_W'(row_length_q);
			default:          prdata = '0;
		endcase
	end

	assign empty_symbol = empty_symbol_q;
	assign row_length   = row_length_q;

endmodule

/* hw/rtl/lessc_front.sv */
// Input stage: request register, column and row counters, line store read issue.
module lessc_front #(
	parameter int MAX_COLS = lessc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lessc_pkg::MAX_ROWS_DEF,
	parameter int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	parameter int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cell_valid,
	output logic                           cell_stall,
	input  logic [lessc_pkg::SYM_W-1:0]    cell_byte,
	input  logic                           last_cell,
	input  logic [lessc_pkg::ROWLEN_W-1:0] row_length,
	input  logic                           fire,
	output lessc_pkg::stage_ctl_t          ctl_s1,
	output logic [lessc_pkg::SYM_W-1:0]    byte_s1,
	output logic [CW-1:0]                  col_s1,
	output logic [RW-1:0]                  row_s1,
	output logic                           rd_en,
	output logic [CW-1:0]                  rd_addr
);
	import lessc_pkg::*;

	localparam int CMP_W = (ROWLEN_W > CW + 1) ? ROWLEN_W : CW + 1;
	localparam logic [RW-1:0]    ROW_MAX  = RW'(MAX_ROWS - 1);
	localparam logic [CMP_W-1:0] COLS_MAX = CMP_W'(MAX_COLS);

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [CMP_W-1:0] rl_x;
	logic [CMP_W-1:0] eff_len;
	logic [CMP_W-1:0] col_inc;
	logic             eol;
	logic             accept;

	assign rl_x = CMP_W'(row_length);

	always_comb begin
		if (row_length == '0) begin
			eff_len = CMP_W'(1);
		end else if (rl_x > COLS_MAX) begin
			eff_len = COLS_MAX;
		end else begin
			eff_len = rl_x;
		end
	end

	assign col_inc    = CMP_W'(col_q) + CMP_W'(1);
	assign eol        = (col_inc >= eff_len);
	assign cell_stall = ctl_s1.valid && !fire;
	assign accept     = cell_valid && !cell_stall;
	assign rd_en      = accept;
	assign rd_addr    = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ctl_s1 <= '0;
		end else begin
			if (accept) begin
				ctl_s1.valid  <= 1'b1;
				ctl_s1.last   <= last_cell;
				ctl_s1.eol    <= eol;
				ctl_s1.row_nz <= (row_q != '0);
				if (last_cell) begin
					col_q <= '0;
					row_q <= '0;
				end else if (eol) begin
					col_q <= '0;
					if (row_q != ROW_MAX) begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end else if (fire) begin
				ctl_s1.valid <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= cell_byte;
			col_s1  <= col_q;
			row_s1  <= row_q;
		end
	end

endmodule

/* hw/rtl/lessc_line_store.sv */
// Previous-row size store: one write and one registered read per cycle, same-edge bypass.
module lessc_line_store #(
	parameter int DEPTH = lessc_pkg::MAX_COLS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	output logic [lessc_pkg::SIZE_W-1:0] rd_data,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [lessc_pkg::SIZE_W-1:0] wr_data
);
	import lessc_pkg::*;

	logic [SIZE_W-1:0] mem [DEPTH];
	logic [SIZE_W-1:0] rdata_q;
	logic [SIZE_W-1:0] byp_data_q;
	logic              byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q    <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// a write on the read edge is not in rdata_q yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rdata_q;

endmodule

/* hw/rtl/lessc_dp.sv */
// Square size recurrence, running best and result register.
module lessc_dp #(
	parameter int CW = $clog2(lessc_pkg::MAX_COLS_DEF),
	parameter int RW = $clog2(lessc_pkg::MAX_ROWS_DEF)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lessc_pkg::stage_ctl_t           ctl_s1,
	input  logic [lessc_pkg::SYM_W-1:0]     byte_s1,
	input  logic [CW-1:0]                   col_s1,
	input  logic [RW-1:0]                   row_s1,
	input  logic [lessc_pkg::SYM_W-1:0]     empty_symbol,
	input  logic [lessc_pkg::SIZE_W-1:0]    up_raw,
	output logic                            fire,
	output logic                            wr_en,
	output logic [CW-1:0]                   wr_addr,
	output logic [lessc_pkg::SIZE_W-1:0]    wr_data,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [lessc_pkg::SIZE_W-1:0]    square_size,
	output logic [lessc_pkg::END_ROW_W-1:0] end_row,
	output logic [lessc_pkg::END_COL_W-1:0] end_col
);
	import lessc_pkg::*;

	logic [SIZE_W-1:0] left_q;
	logic [SIZE_W-1:0] diag_q;
	logic [SIZE_W-1:0] best_size_q;
	logic [RW-1:0]     best_row_q;
	logic [CW-1:0]     best_col_q;
	logic [SIZE_W-1:0] up;
	logic [SIZE_W-1:0] m_lu;
	logic [SIZE_W-1:0] m_all;
	logic [SIZE_W-1:0] val;
	logic              better;
	logic [SIZE_W-1:0] new_size;
	logic [RW-1:0]     new_row;
	logic [CW-1:0]     new_col;
	logic              out_free;

	assign up    = ctl_s1.row_nz ? up_raw : '0;
	assign m_lu  = (left_q < up) ? left_q : up;
	assign m_all = (m_lu < diag_q) ? m_lu : diag_q;
	assign val   = (byte_s1 == empty_symbol) ? m_all + SIZE_W'(1) : '0;

	assign better   = (val > best_size_q);
	assign new_size = better ? val : best_size_q;
	assign new_row  = better ? row_s1 : best_row_q;
	assign new_col  = better ? col_s1 : best_col_q;

	assign out_free = !result_valid || !result_stall;
	assign fire     = ctl_s1.valid && (!ctl_s1.last || out_free);
	assign wr_en    = fire;
	assign wr_addr  = col_s1;
	assign wr_data  = val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			diag_q       <= '0;
			best_size_q  <= '0;
			best_row_q   <= '0;
			best_col_q   <= '0;
			result_valid <= 1'b0;
		end else begin
			if (fire && ctl_s1.last) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			if (fire) begin
				if (ctl_s1.last) begin
					left_q      <= '0;
					diag_q      <= '0;
					best_size_q <= '0;
					best_row_q  <= '0;
					best_col_q  <= '0;
				end else begin
					left_q      <= ctl_s1.eol ? '0 : val;
					diag_q      <= ctl_s1.eol ? '0 : up;
					best_size_q <= new_size;
					best_row_q  <= new_row;
					best_col_q  <= new_col;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl_s1.last) begin
			square_size <= new_size;
			end_row     <= END_ROW_W'(new_row);
			end_col     <= END_COL_W'(new_col);
		end
	end

endmodule

/* hw/rtl/largest_empty_square_scan_core.sv */
// Top level of the largest empty square scan core.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+----------------------------------
//   cell      | cell_valid / cell_stall    | cell_byte, last_cell
//   result    | result_valid / result_stall| square_size, end_row, end_col
//   config    | psel, penable, pwrite      | paddr, pwdata, prdata (pready = 1)
//
// One cell request per clock unless a last cell waits on a stalled result; the
// rate is set by the single line store port pair (one read, one write each cycle).
// The result of a map is registered when its last cell retires from the compute stage.
// arst_n clears counters, running best, left/diagonal sizes and valids;
// the line store holds junk until the first row of a map writes it.
// A stalled result only holds up the cell path when the next last cell
// reaches the compute stage; other cells keep flowing.
module largest_empty_square_scan_core #(
	parameter int MAX_COLS = lessc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lessc_pkg::MAX_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lessc_pkg::PADDR_W-1:0]   paddr,
	input  logic [lessc_pkg::PDATA_W-1:0]   pwdata,
	output logic [lessc_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	input  logic                            cell_valid,
	output logic                            cell_stall,
	input  logic [lessc_pkg::SYM_W-1:0]     cell_byte,
	input  logic                            last_cell,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [lessc_pkg::SIZE_W-1:0]    square_size,
	output logic [lessc_pkg::END_ROW_W-1:0] end_row,
	output logic [lessc_pkg::END_COL_W-1:0] end_col
);
	import lessc_pkg::*;

	// column index and row counter widths follow the map limits
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [SYM_W-1:0]    empty_symbol;
	logic [ROWLEN_W-1:0] row_length;

	// compute stage contents
	stage_ctl_t          ctl_s1;
	logic [SYM_W-1:0]    byte_s1;
	logic [CW-1:0]       col_s1;
	logic [RW-1:0]       row_s1;

	// line store traffic
	logic                rd_en;
	logic [CW-1:0]       rd_addr;
	logic [SIZE_W-1:0]   up_raw;
	logic                wr_en;
	logic [CW-1:0]       wr_addr;
	logic [SIZE_W-1:0]   wr_data;

	logic                fire;   // compute stage retires its request

	lessc_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.empty_symbol (empty_symbol),
		.row_length   (row_length)
	);

	// Front: takes a request, steps column/row and issues the read of the
	// size above, so the data is ready when the request is computed.
	lessc_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.CW       (CW),
		.RW       (RW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_byte  (cell_byte),
		.last_cell  (last_cell),
		.row_length (row_length),
		.fire       (fire),
		.ctl_s1     (ctl_s1),
		.byte_s1    (byte_s1),
		.col_s1     (col_s1),
		.row_s1     (row_s1),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr)
	);

	// Line store: a write from the retiring request on the same edge as
	// a read of that column is bypassed (single-column rows).
	lessc_line_store #(
		.DEPTH (MAX_COLS),
		.AW    (CW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (up_raw),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// min of left/up/diagonal plus one (zero for a non-empty cell), running best, result register
	lessc_dp #(
		.CW (CW),
		.RW (RW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.byte_s1      (byte_s1),
		.col_s1       (col_s1),
		.row_s1       (row_s1),
		.empty_symbol (empty_symbol),
		.up_raw       (up_raw),
		.fire         (fire),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.square_size  (square_size),
		.end_row      (end_row),
		.end_col      (end_col)
	);

endmodule

/* hw/rtl/lessc_chk.sv */
// Port-level checker for the scan core, bound to the top level.
`include "largest_empty_square_scan_core_macros.svh"

module lessc_chk #(
	parameter int MAX_COLS = lessc_pkg::MAX_COLS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic [lessc_pkg::SIZE_W-1:0]    square_size,
	input logic [lessc_pkg::END_ROW_W-1:0] end_row,
	input logic [lessc_pkg::END_COL_W-1:0] end_col
);
	import lessc_pkg::*;

	`LESSC_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid, "result dropped while stalled")
	`LESSC_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(square_size) && $stable(end_row) && $stable(end_col), "stalled result changed")
	`LESSC_ASSERT_NOW(a_empty_pos, result_valid && (square_size == '0), (end_row == '0) && (end_col == '0), "no square but position not zero")
	`LESSC_ASSERT_NOW(a_size_bound, result_valid, (square_size <= MAX_COLS) && (end_col < MAX_COLS), "square wider than a row")

endmodule

bind largest_empty_square_scan_core lessc_chk #(.MAX_COLS(MAX_COLS)) u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.square_size  (square_size),
	.end_row      (end_row),
	.end_col      (end_col)
);

/* sim/largest_empty_square_scan_checker.sv */
// Checker for the scan core: mirrors the register writes, predicts each square and compares results.
module largest_empty_square_scan_checker #(
	parameter int MAX_COLS = lessc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lessc_pkg::MAX_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [lessc_pkg::PADDR_W-1:0]   paddr,
	input  logic [lessc_pkg::PDATA_W-1:0]   pwdata,
	input  logic                            cell_valid,
	input  logic                            cell_stall,
	input  logic [lessc_pkg::SYM_W-1:0]     cell_byte,
	input  logic                            last_cell,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  logic [lessc_pkg::SIZE_W-1:0]    square_size,
	input  logic [lessc_pkg::END_ROW_W-1:0] end_row,
	input  logic [lessc_pkg::END_COL_W-1:0] end_col,
	output int                              fail_count,
	output int                              squares_due
);
	import lessc_pkg::*;

	typedef struct packed {
		logic [SIZE_W-1:0]    size;
		logic [END_ROW_W-1:0] row;
		logic [END_COL_W-1:0] col;
	} square_t;

	logic [SYM_W-1:0]    empty_sym;
	logic [ROWLEN_W-1:0] row_len;
	logic [SIZE_W-1:0]   line_sizes [MAX_COLS];
	logic [SIZE_W-1:0]   left_sz, diag_sz;
	int unsigned         col_idx, row_idx;
	square_t             best;
	square_t             pending_squares [$];
	int                  errors = 0;

	task automatic clear_scan();
		left_sz = '0;
		diag_sz = '0;
		col_idx = 0;
		row_idx = 0;
		best    = '0;
	endtask

	// one map cell through the recurrence; a last cell queues the map's best square
	task automatic predict_cell(input logic [SYM_W-1:0] ch, input logic last);
		logic [SIZE_W-1:0] up, val, m;
		int unsigned       c, len;
		c   = (col_idx >= MAX_COLS) ? MAX_COLS - 1 : col_idx;
		len = (row_len == 0) ? 1 : ((row_len > MAX_COLS) ? MAX_COLS : row_len);
		up  = (row_idx != 0) ? line_sizes[c] : '0;
		val = '0;
		if (ch == empty_sym) begin
			m   = (left_sz < up) ? left_sz : up;
			m   = (m < diag_sz) ? m : diag_sz;
			val = m + 1'b1;
		end
		line_sizes[c] = val;
		diag_sz       = up;
		left_sz       = val;
		if (val > best.size)
			best = '{val, END_ROW_W'(row_idx), END_COL_W'(c)};
		if (last) begin
			pending_squares.push_back(best);
			clear_scan();
		end else if (c + 1 >= len) begin
			col_idx = 0;
			left_sz = '0;
			diag_sz = '0;
			if (row_idx + 1 < MAX_ROWS)
				row_idx++;
		end else begin
			col_idx = c + 1;
		end
	endtask

	task automatic check_square();
		square_t want;
		if (pending_squares.size() == 0) begin
			$error("unexpected result: size %0d row %0d col %0d", square_size, end_row, end_col);
			errors++;
			return;
		end
		want = pending_squares.pop_front();
		if (square_size !== want.size) begin
			$error("square_size: expected %0d, got %0d", want.size, square_size);
			errors++;
		end
		if (end_row !== want.row) begin
			$error("end_row: expected %0d, got %0d", want.row, end_row);
			errors++;
		end
		if (end_col !== want.col) begin
			$error("end_col: expected %0d, got %0d", want.col, end_col);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_sym = EMPTY_SYMBOL_RST;
			row_len   = ROW_LENGTH_RST;
			for (int i = 0; i < MAX_COLS; i++)
				line_sizes[i] = '0;
			clear_scan();
			pending_squares.delete();
		end else begin
			// a cell taken at this edge still sees the old registers
			if (cell_valid && !cell_stall)
				predict_cell(cell_byte, last_cell);
			if (result_valid && !result_stall)
				check_square();
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_EMPTY_SYMBOL: empty_sym = pwdata[SYM_W-1:0];
					REG_ROW_LENGTH:   row_len   = pwdata[ROWLEN_W-1:0];
					default:          ;
				endcase
			end
		end
		squares_due <= pending_squares.size();
		fail_count  <= errors;
	end

endmodule

/* sim/largest_empty_square_scan_core_tb.sv */
// Testbench top for the scan core: clock, reset, map stimulus, result stalls and verdict.
module largest_empty_square_scan_core_tb;
	import lessc_pkg::*;

	localparam int PERIOD       = 8;
	localparam int RESET_CYCLES = 5;
	localparam int DRAIN_CYCLES = 6;    // result is registered once its last cell retires
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
	localparam int QUIET_LIMIT  = 4000; // cycles with nothing taken before giving up
	localparam int RANDOM_CELLS = 1050;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel, penable, pwrite, pready;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata, prdata;
	logic                 cell_valid, cell_stall, last_cell;
	logic [SYM_W-1:0]     cell_byte;
	logic                 result_valid, result_stall;
	logic [SIZE_W-1:0]    square_size;
	logic [END_ROW_W-1:0] end_row;
	logic [END_COL_W-1:0] end_col;
	int                   fail_count, squares_due;

	// stimulus-side copy of the registers, only used to shape the maps
	logic [SYM_W-1:0]    empty_sym_cfg = EMPTY_SYMBOL_RST;
	logic [ROWLEN_W-1:0] row_len_cfg   = ROW_LENGTH_RST;
	bit                  calm          = 1'b0; // no random idling on either side
	int                  cells_sent    = 0;
	int                  holds_asked   = 0;

	largest_empty_square_scan_core uut (.*);

	largest_empty_square_scan_checker square_check (.*);

	always #(PERIOD / 2) clk = ~clk;

	// mostly back-to-back, some short gaps, the odd long one
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int eff_len();
		if (row_len_cfg == 0)
			return 1;
		if (row_len_cfg > MAX_COLS_DEF)
			return MAX_COLS_DEF;
		return row_len_cfg;
	endfunction

	function automatic logic [SYM_W-1:0] pick_cell(input int pct_empty);
		if ($urandom_range(1, 100) <= pct_empty)
			return empty_sym_cfg;
		return SYM_W'($urandom_range(0, 255));
	endfunction

	// two-phase register write; ends with an idle step after the access so the
	// next write starts in a fresh step
	task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (idx == REG_EMPTY_SYMBOL)
			empty_sym_cfg = value[SYM_W-1:0];
		else
			row_len_cfg = value[ROWLEN_W-1:0];
	endtask

	// one cell request; valid stays up across back-to-back requests
	task automatic send_cell(input logic [SYM_W-1:0] ch, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_byte  <= ch;
		last_cell  <= last;
		do @(posedge clk); while (cell_stall);
		cells_sent++;
	endtask

	task automatic send_cells(input int count, input int pct_empty, input bit end_map);
		for (int i = 0; i < count; i++)
			send_cell(pick_cell(pct_empty), end_map && (i == count - 1));
	endtask

	// stop offering, let every awaited square come out, then allow for
	// cells still in the pipe that carry no result
	task automatic settle();
		cell_valid <= 1'b0;
		@(posedge clk);
		while (squares_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver: random stalls, plus the long hold-off when one is asked for
	initial begin
		int n;
		int holds_served = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					result_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog: too long with no request taken on any port
	initial begin
		int quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cell_valid && !cell_stall) || (result_valid && !result_stall) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL largest_empty_square_scan_core");
		$finish;
	end

	initial begin
		int len, pct, kind, maps, n1;
		arst_n     = 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		cell_valid <= 1'b0;
		cell_byte  <= '0;
		last_cell  <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset registers: '.' empty, rows of 1024; single-cell maps
		send_cell(8'h2E, 1'b1);           // one empty cell: square 1 at the origin
		send_cell(8'hFF, 1'b1);           // top byte, not empty: no square
		send_cell(8'h00, 1'b1);           // bottom byte, not empty
		settle();
		reg_write(REG_ROW_LENGTH, 3);
		repeat (8) send_cell(8'h2E, 1'b0);
		send_cell(8'h2E, 1'b1);           // full 3x3 block: side 3 ending at (2,2)
		// equal sizes later on must not replace the first one
		send_cell(8'h23, 1'b0);
		send_cell(8'h2E, 1'b0);
		send_cell(8'h23, 1'b0);
		send_cell(8'h2E, 1'b0);
		send_cell(8'h2E, 1'b0);
		send_cell(8'h23, 1'b1);
		settle();
		reg_write(REG_EMPTY_SYMBOL, 8'hFF);
		send_cell(8'hFF, 1'b0);
		send_cell(8'h00, 1'b1);
		settle();
		reg_write(REG_EMPTY_SYMBOL, 8'h00);
		send_cell(8'h00, 1'b1);
		settle();

		// --- random maps, phase by phase ---
		while (cells_sent < RANDOM_CELLS) begin
			reg_write(REG_EMPTY_SYMBOL, ($urandom_range(0, 9) < 4) ? 8'h2E
				: $urandom_range(0, 255));
			kind = $urandom_range(0, 9);
			len  = (kind < 6) ? $urandom_range(1, 8)
				: ((kind < 9) ? $urandom_range(9, 32) : $urandom_range(33, 100));
			reg_write(REG_ROW_LENGTH, len);
			calm = ($urandom_range(0, 3) == 0);
			maps = $urandom_range(1, 4);
			repeat (maps) begin
				pct  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60)
					: $urandom_range(70, 98);
				kind = $urandom_range(0, 9);
				len  = eff_len();
				if (kind < 6) begin
					// whole rows
					send_cells(len * $urandom_range(1, (len <= 8) ? 8 : 3), pct, 1'b1);
				end else if (kind < 8) begin
					// map cut off anywhere
					send_cells($urandom_range(1, 4 * len), pct, 1'b1);
				end else begin
					// shorter rows from the middle of a map on; only
					// shrinking, so every column read was written above
					n1 = $urandom_range(len, 3 * len);
					send_cells(n1, pct, 1'b0);
					settle();
					reg_write(REG_ROW_LENGTH, $urandom_range(1, len));
					send_cells($urandom_range(1, 3 * eff_len()), pct, 1'b1);
				end
			end
			settle();
		end

		// --- back-pressure: receiver holds off while tiny maps keep coming ---
		calm = 1'b1;
		reg_write(REG_EMPTY_SYMBOL, 8'h2E);
		reg_write(REG_ROW_LENGTH, 2);
		holds_asked++;
		repeat (40) send_cells($urandom_range(1, 3), 70, 1'b1);
		settle();

		// --- over-long row setting: no row end within a short map ---
		calm = 1'b0;
		reg_write(REG_ROW_LENGTH, 2047);
		send_cells(40, 80, 1'b1);
		settle();

		// --- zero row length acts as 1: one column per row ---
		calm = 1'b1;
		reg_write(REG_ROW_LENGTH, 0);
		send_cells(12, 90, 1'b1);
		settle();

		if (fail_count == 0 && squares_due == 0)
			$display("PASS largest_empty_square_scan_core");
		else
			$display("FAIL largest_empty_square_scan_core");
		$finish;
	end

endmodule
